// File: hdl/array_linked_list_with_free_list_defines.svh
// Assertion macros for the linked-list block.
// Included by the top level; depends on nothing else.
`ifndef ARRAY_LINKED_LIST_WITH_FREE_LIST_DEFINES_SVH
`define ARRAY_LINKED_LIST_WITH_FREE_LIST_DEFINES_SVH

// Implication in the same cycle, disabled while reset is asserted.
`define ALFL_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication in the next cycle, disabled while reset is asserted.
`define ALFL_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// File: hdl/alfl_pkg.sv
// Shared types and constants for the linked-list block.
// Used by alfl_store and array_linked_list_with_free_list; no dependencies.
package alfl_pkg;

    localparam int SLOTS_DEF   = 16;
    localparam int MAX_RESULTS = 16;
    localparam int SLOT_W      = 6;
    localparam int DATA_W      = 32;
    localparam int KIND_W      = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_APPEND = 2'd0,
        KIND_SEARCH = 2'd1,
        KIND_REMOVE = 2'd2,
        KIND_LIST   = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_APOP,
        ST_ALINK,
        ST_AWALK,
        ST_AEVAL,
        ST_SRD,
        ST_SEVAL,
        ST_RRD,
        ST_REVAL,
        ST_RFREE,
        ST_LRD,
        ST_LEVAL,
        ST_OUT
    } state_t;

    // Write strobes from the sequencer to the slot store.
    typedef struct packed {
        logic link_we;
        logic ent_we;
    } wr_t;

endpackage

// File: hdl/alfl_store.sv
// Slot store: link, key and value memories with one registered read port.
// Depends on alfl_pkg.
module alfl_store #(
    parameter int SLOTS = alfl_pkg::SLOTS_DEF,
    parameter int PW    = $clog2(SLOTS + 1)
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  alfl_pkg::wr_t              wr,
    input  logic [PW-1:0]              link_waddr,
    input  logic [PW-1:0]              link_wdata,
    input  logic [PW-1:0]              ent_waddr,
    input  logic [alfl_pkg::DATA_W-1:0] key_wdata,
    input  logic [alfl_pkg::DATA_W-1:0] value_wdata,
    input  logic [PW-1:0]              rd_addr,
    output logic [PW-1:0]              rd_link,
    output logic [alfl_pkg::DATA_W-1:0] rd_key,
    output logic [alfl_pkg::DATA_W-1:0] rd_value
);

    localparam int IW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

    logic [PW-1:0]               link_mem [SLOTS];
    logic [alfl_pkg::DATA_W-1:0] key_mem  [SLOTS];
    logic [alfl_pkg::DATA_W-1:0] value_mem[SLOTS];
    logic [SLOTS-1:0]            link_vld_reg;

    logic [PW-1:0] link_q_reg;
    logic          vld_q_reg;
    logic [PW-1:0] addr_q_reg;

    logic [IW-1:0] rd_idx;
    logic [IW-1:0] link_widx;
    logic [IW-1:0] ent_widx;

    assign rd_idx    = rd_addr[IW-1:0];
    assign link_widx = link_waddr[IW-1:0];
    assign ent_widx  = ent_waddr[IW-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            link_vld_reg <= '0;
        end else if (wr.link_we) begin
            link_vld_reg[link_widx] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.link_we) begin
            link_mem[link_widx] <= link_wdata;
        end
        link_q_reg <= link_mem[rd_idx];
        vld_q_reg  <= link_vld_reg[rd_idx];
        addr_q_reg <= rd_addr;
    end

    always_ff @(posedge aclk) begin
        if (wr.ent_we) begin
            key_mem[ent_widx]   <= key_wdata;
            value_mem[ent_widx] <= value_wdata;
        end
        rd_key   <= key_mem[rd_idx];
        rd_value <= value_mem[rd_idx];
    end

    // A link never written since reset still holds its chained value i + 1.
    assign rd_link = vld_q_reg ? link_q_reg : PW'(addr_q_reg + 1'b1);

endmodule

// File: hdl/array_linked_list_with_free_list.sv
// Append pops the free head, then walks entry by entry to the tail; search and remove
// visit entries from the head; list emits one entry per visit, each through the output handshake.
// One request at a time: a new request is taken only once the last result is accepted. The
// slowest request is a list of a full pool, each entry read through the single registered read
// port of the slot store and then handed through the output handshake.
// Reset: synchronous active low; lists and link valid bits clear at once.
module array_linked_list_with_free_list #(
    parameter int SLOTS = alfl_pkg::SLOTS_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [alfl_pkg::KIND_W-1:0] s_kind,
    input  logic signed [alfl_pkg::DATA_W-1:0] s_key,
    input  logic [alfl_pkg::DATA_W-1:0] s_value,
    input  logic [alfl_pkg::SLOT_W-1:0] s_slot,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic                        m_ok,
    output logic [alfl_pkg::SLOT_W-1:0] m_slot_out,
    output logic signed [alfl_pkg::DATA_W-1:0] m_key_out,
    output logic [alfl_pkg::DATA_W-1:0] m_value_out,
    output logic                        m_last
);

`include "array_linked_list_with_free_list_defines.svh"

    // Slot pointers carry one extra code, SLOTS itself, which stands for null.
    localparam int PW   = $clog2(SLOTS + 1);
    localparam int NMAX = (SLOTS > alfl_pkg::MAX_RESULTS) ? SLOTS : alfl_pkg::MAX_RESULTS;
    localparam int NW   = $clog2(NMAX + 1);
    localparam int CMPW = (PW > alfl_pkg::SLOT_W) ? PW : alfl_pkg::SLOT_W;
    localparam logic [PW-1:0] NIL = PW'(SLOTS);

    alfl_pkg::state_t state_reg, state_next;

    // Latched request fields.
    logic [alfl_pkg::DATA_W-1:0]  key_reg, key_next;
    logic [alfl_pkg::DATA_W-1:0]  value_reg, value_next;
    logic [alfl_pkg::SLOT_W-1:0]  slot_reg, slot_next;

    // Walk state: current node, its predecessor, the step count and the new slot.
    logic [PW-1:0] cur_reg, cur_next;
    logic [PW-1:0] prev_reg, prev_next;
    logic [PW-1:0] new_reg, new_next;
    logic [NW-1:0] n_reg, n_next;

    // List heads.
    logic [PW-1:0] used_head_reg, used_head_next;
    logic [PW-1:0] free_head_reg, free_head_next;

    // Result register; it holds an item until the consumer takes it.
    logic                         ok_reg, ok_next;
    logic [alfl_pkg::SLOT_W-1:0]  slot_out_reg, slot_out_next;
    logic [alfl_pkg::DATA_W-1:0]  key_out_reg, key_out_next;
    logic [alfl_pkg::DATA_W-1:0]  value_out_reg, value_out_next;
    logic                         last_reg, last_next;

    // Store interface.
    alfl_pkg::wr_t               wr;
    logic [PW-1:0]               link_waddr;
    logic [PW-1:0]               link_wdata;
    logic [PW-1:0]               rd_addr;
    logic [PW-1:0]               rd_link;
    logic [alfl_pkg::DATA_W-1:0] rd_key;
    logic [alfl_pkg::DATA_W-1:0] rd_value;

    logic do_fail;
    logic walk_done;
    logic slot_hit;
    logic key_hit;

    alfl_store #(
        .SLOTS (SLOTS),
        .PW    (PW)
    ) u_store (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .wr          (wr),
        .link_waddr  (link_waddr),
        .link_wdata  (link_wdata),
        .ent_waddr   (free_head_reg),
        .key_wdata   (key_reg),
        .value_wdata (value_reg),
        .rd_addr     (rd_addr),
        .rd_link     (rd_link),
        .rd_key      (rd_key),
        .rd_value    (rd_value)
    );

    // The only read port looks at the free head while popping it and at the
    // walk pointer in every other state.
    assign rd_addr = (state_reg == alfl_pkg::ST_APOP) ? free_head_reg : cur_reg;

    // A walk ends at null, and is bounded by the pool size should a link ever loop.
    assign walk_done = (cur_reg >= NIL) || (n_reg >= NW'(SLOTS));
    assign slot_hit  = (CMPW'(cur_reg) == CMPW'(slot_reg));
    assign key_hit   = (rd_key == key_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= alfl_pkg::ST_IDLE;
            used_head_reg <= NIL;
            free_head_reg <= '0;
        end else begin
            state_reg     <= state_next;
            used_head_reg <= used_head_next;
            free_head_reg <= free_head_next;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg       <= key_next;
        value_reg     <= value_next;
        slot_reg      <= slot_next;
        cur_reg       <= cur_next;
        prev_reg      <= prev_next;
        new_reg       <= new_next;
        n_reg         <= n_next;
        ok_reg        <= ok_next;
        slot_out_reg  <= slot_out_next;
        key_out_reg   <= key_out_next;
        value_out_reg <= value_out_next;
        last_reg      <= last_next;
    end

    always_comb begin
        state_next     = state_reg;
        key_next       = key_reg;
        value_next     = value_reg;
        slot_next      = slot_reg;
        cur_next       = cur_reg;
        prev_next      = prev_reg;
        new_next       = new_reg;
        n_next         = n_reg;
        used_head_next = used_head_reg;
        free_head_next = free_head_reg;
        ok_next        = ok_reg;
        slot_out_next  = slot_out_reg;
        key_out_next   = key_out_reg;
        value_out_next = value_out_reg;
        last_next      = last_reg;
        wr             = '0;
        link_waddr     = cur_reg;
        link_wdata     = NIL;
        do_fail        = 1'b0;

        case (state_reg)
            alfl_pkg::ST_IDLE: begin
                if (s_valid) begin
                    key_next   = s_key;
                    value_next = s_value;
                    slot_next  = s_slot;
                    cur_next   = used_head_reg;
                    prev_next  = NIL;
                    n_next     = '0;
                    case (alfl_pkg::kind_t'(s_kind))
                        alfl_pkg::KIND_APPEND: begin
                            if (free_head_reg >= NIL) begin
                                do_fail = 1'b1;
                            end else begin
                                state_next = alfl_pkg::ST_APOP;
                            end
                        end
                        alfl_pkg::KIND_SEARCH: begin
                            state_next = alfl_pkg::ST_SRD;
                        end
                        alfl_pkg::KIND_REMOVE: begin
                            if (CMPW'(s_slot) >= CMPW'(SLOTS)) begin
                                do_fail = 1'b1;
                            end else begin
                                state_next = alfl_pkg::ST_RRD;
                            end
                        end
                        alfl_pkg::KIND_LIST: begin
                            if (used_head_reg >= NIL) begin
                                do_fail = 1'b1;
                            end else begin
                                state_next = alfl_pkg::ST_LRD;
                            end
                        end
                        default: begin
                            do_fail = 1'b1;
                        end
                    endcase
                end
            end

            // Append: the free head is being read; its link becomes the new free head.
            alfl_pkg::ST_APOP: begin
                state_next = alfl_pkg::ST_ALINK;
            end

            alfl_pkg::ST_ALINK: begin
                new_next       = free_head_reg;
                free_head_next = rd_link;
                wr.ent_we      = 1'b1;
                wr.link_we     = 1'b1;
                link_waddr     = free_head_reg;
                link_wdata     = NIL;
                ok_next        = 1'b1;
                slot_out_next  = alfl_pkg::SLOT_W'(free_head_reg);
                key_out_next   = key_reg;
                value_out_next = value_reg;
                last_next      = 1'b1;
                if (used_head_reg >= NIL) begin
                    used_head_next = free_head_reg;
                    state_next     = alfl_pkg::ST_OUT;
                end else begin
                    cur_next   = used_head_reg;
                    n_next     = '0;
                    state_next = alfl_pkg::ST_AWALK;
                end
            end

            alfl_pkg::ST_AWALK: begin
                state_next = alfl_pkg::ST_AEVAL;
            end

            // Follow links to the tail, then hook the new slot behind it.
            alfl_pkg::ST_AEVAL: begin
                if ((rd_link < NIL) && (n_reg < NW'(SLOTS))) begin
                    cur_next   = rd_link;
                    n_next     = NW'(n_reg + 1'b1);
                    state_next = alfl_pkg::ST_AWALK;
                end else begin
                    wr.link_we = 1'b1;
                    link_waddr = cur_reg;
                    link_wdata = new_reg;
                    state_next = alfl_pkg::ST_OUT;
                end
            end

            alfl_pkg::ST_SRD: begin
                if (walk_done) begin
                    do_fail = 1'b1;
                end else begin
                    state_next = alfl_pkg::ST_SEVAL;
                end
            end

            // Search: the key comparator checks one stored key per step.
            alfl_pkg::ST_SEVAL: begin
                if (key_hit) begin
                    ok_next        = 1'b1;
                    slot_out_next  = alfl_pkg::SLOT_W'(cur_reg);
                    key_out_next   = rd_key;
                    value_out_next = rd_value;
                    last_next      = 1'b1;
                    state_next     = alfl_pkg::ST_OUT;
                end else begin
                    cur_next   = rd_link;
                    n_next     = NW'(n_reg + 1'b1);
                    state_next = alfl_pkg::ST_SRD;
                end
            end

            alfl_pkg::ST_RRD: begin
                if (walk_done) begin
                    do_fail = 1'b1;
                end else begin
                    state_next = alfl_pkg::ST_REVAL;
                end
            end

            // Remove: on a hit, bypass the node from its predecessor or from the head.
            alfl_pkg::ST_REVAL: begin
                if (slot_hit) begin
                    if (prev_reg >= NIL) begin
                        used_head_next = rd_link;
                    end else begin
                        wr.link_we = 1'b1;
                        link_waddr = prev_reg;
                        link_wdata = rd_link;
                    end
                    ok_next        = 1'b1;
                    slot_out_next  = alfl_pkg::SLOT_W'(cur_reg);
                    key_out_next   = rd_key;
                    value_out_next = rd_value;
                    last_next      = 1'b1;
                    state_next     = alfl_pkg::ST_RFREE;
                end else begin
                    prev_next  = cur_reg;
                    cur_next   = rd_link;
                    n_next     = NW'(n_reg + 1'b1);
                    state_next = alfl_pkg::ST_RRD;
                end
            end

            // Push the removed slot onto the free list.
            alfl_pkg::ST_RFREE: begin
                wr.link_we     = 1'b1;
                link_waddr     = cur_reg;
                link_wdata     = free_head_reg;
                free_head_next = cur_reg;
                state_next     = alfl_pkg::ST_OUT;
            end

            alfl_pkg::ST_LRD: begin
                state_next = alfl_pkg::ST_LEVAL;
            end

            // List: one entry per visit; the run ends at the tail or at the result limit.
            alfl_pkg::ST_LEVAL: begin
                ok_next        = 1'b1;
                slot_out_next  = alfl_pkg::SLOT_W'(cur_reg);
                key_out_next   = rd_key;
                value_out_next = rd_value;
                last_next      = (rd_link >= NIL) ||
                                 (n_reg == NW'(alfl_pkg::MAX_RESULTS - 1));
                cur_next       = rd_link;
                n_next         = NW'(n_reg + 1'b1);
                state_next     = alfl_pkg::ST_OUT;
            end

            alfl_pkg::ST_OUT: begin
                if (m_ready) begin
                    state_next = last_reg ? alfl_pkg::ST_IDLE : alfl_pkg::ST_LRD;
                end
            end

            default: begin
                state_next = alfl_pkg::ST_IDLE;
            end
        endcase

        // A failed request gives one all-zero result that closes the run.
        if (do_fail) begin
            ok_next        = 1'b0;
            slot_out_next  = '0;
            key_out_next   = '0;
            value_out_next = '0;
            last_next      = 1'b1;
            state_next     = alfl_pkg::ST_OUT;
        end
    end

    assign s_ready     = (state_reg == alfl_pkg::ST_IDLE);
    assign m_valid     = (state_reg == alfl_pkg::ST_OUT);
    assign m_ok        = ok_reg;
    assign m_slot_out  = slot_out_reg;
    assign m_key_out   = key_out_reg;
    assign m_value_out = value_out_reg;
    assign m_last      = last_reg;

    // The block never takes a new item while a result is waiting.
    `ALFL_ASSERT_SAME(a_ready_excl, aclk, aresetn, s_ready, !m_valid)
    // An accepted item always keeps the block busy in the following cycle.
    `ALFL_ASSERT_NEXT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready, !s_ready)
    // A failure result is all zero and closes its run.
    `ALFL_ASSERT_SAME(a_fail_shape, aclk, aresetn, m_valid && !m_ok,
        m_last && (m_slot_out == '0) && (m_key_out == '0) && (m_value_out == '0))
    // One slot can never head both the used list and the free list.
    `ALFL_ASSERT_SAME(a_heads_apart, aclk, aresetn, used_head_reg < NIL,
        used_head_reg != free_head_reg)

endmodule

// File: sim/tb_array_linked_list_with_free_list.sv
// Self-checking testbench for array_linked_list_with_free_list: appends, searches,
// removals and list walks against an in-bench model of the slot pool.
// Depends on alfl_pkg and the block's RTL only.
module tb_array_linked_list_with_free_list;
    import alfl_pkg::*;

    localparam int SLOTS       = SLOTS_DEF;
    localparam int LINK_W      = $clog2(SLOTS + 1);
    localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOTS);
    // No acceptance on either side for this many cycles means the block hung.
    // The slowest correct stretch is the forced output hold plus a long
    // sender gap plus a full list walk, well under this.
    localparam int STUCK_LIMIT = 2000;
    localparam int DRAIN_CYCLES = 80;

    // One result item as the block presents it.
    typedef struct packed {
        logic              ok;
        logic [SLOT_W-1:0] slot;
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
        logic              last;
    } reply_t;

    logic                      aclk;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [KIND_W-1:0]         s_kind  = '0;
    logic signed [DATA_W-1:0]  s_key   = '0;
    logic [DATA_W-1:0]         s_value = '0;
    logic [SLOT_W-1:0]         s_slot  = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic                      m_ok;
    logic [SLOT_W-1:0]         m_slot_out;
    logic signed [DATA_W-1:0]  m_key_out;
    logic [DATA_W-1:0]         m_value_out;
    logic                      m_last;

    // Pool model: links, record contents and the heads of both lists.
    logic [LINK_W-1:0] link_tbl  [SLOTS];
    logic [DATA_W-1:0] key_tbl   [SLOTS];
    logic [DATA_W-1:0] value_tbl [SLOTS];
    logic [LINK_W-1:0] used_top;
    logic [LINK_W-1:0] free_top;

    reply_t pending_replies[$];
    reply_t head_reply;
    int     mismatches = 0;

    // Traffic shaping shared by the sender and the receiver. While calm is
    // set neither side idles; hold_len asks the receiver for one long stall.
    bit     calm     = 1'b0;
    int     hold_len = 0;
    int     stuck    = 0;

    logic [DATA_W-1:0] key_pool [6] = '{32'h8000_0000, 32'h7fff_ffff, 32'h0000_0000,
                                        32'hffff_ffff, 32'h0000_0001, 32'h5555_5555};

    array_linked_list_with_free_list #(
        .SLOTS(SLOTS)
    ) i_dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_kind     (s_kind),
        .s_key      (s_key),
        .s_value    (s_value),
        .s_slot     (s_slot),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_ok       (m_ok),
        .m_slot_out (m_slot_out),
        .m_key_out  (m_key_out),
        .m_value_out(m_value_out),
        .m_last     (m_last)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------
    // Pool model
    // ------------------------------------------------------------------

    // After reset every slot is chained on the free list in index order and
    // the used list is empty.
    task automatic reset_pool();
        for (int i = 0; i < SLOTS; i++) begin
            link_tbl[i]  = (i + 1 < SLOTS) ? LINK_W'(i + 1) : NIL;
            key_tbl[i]   = '0;
            value_tbl[i] = '0;
        end
        used_top = NIL;
        free_top = '0;
    endtask

    task automatic push_reply(logic ok, logic [SLOT_W-1:0] slot, logic [DATA_W-1:0] key,
                              logic [DATA_W-1:0] value, logic last);
        reply_t r;
        r.ok    = ok;
        r.slot  = slot;
        r.key   = key;
        r.value = value;
        r.last  = last;
        pending_replies.push_back(r);
    endtask

    // Any failing request yields exactly one all-zero item flagged as last.
    task automatic push_failure();
        push_reply(1'b0, '0, '0, '0, 1'b1);
    endtask

    // Applies one accepted request to the pool model and queues the items
    // the block has to return for it.
    task automatic predict_pool_request(kind_t kind, logic [DATA_W-1:0] key,
                                        logic [DATA_W-1:0] value, logic [SLOT_W-1:0] slot);
        logic [LINK_W-1:0] cur;
        logic [LINK_W-1:0] prv;
        logic [LINK_W-1:0] taken;
        int                n;
        case (kind)
            KIND_APPEND: begin
                if (free_top == NIL) begin
                    push_failure();
                end else begin
                    taken           = free_top;
                    free_top        = link_tbl[taken];
                    key_tbl[taken]  = key;
                    value_tbl[taken] = value;
                    link_tbl[taken] = NIL;
                    if (used_top == NIL) begin
                        used_top = taken;
                    end else begin
                        cur = used_top;
                        while (link_tbl[cur] != NIL) cur = link_tbl[cur];
                        link_tbl[cur] = taken;
                    end
                    push_reply(1'b1, SLOT_W'(taken), key, value, 1'b1);
                end
            end
            KIND_SEARCH: begin
                // Keys compare as raw bits; the first match from the head wins.
                cur = used_top;
                while (cur != NIL && key_tbl[cur] != key) cur = link_tbl[cur];
                if (cur == NIL) begin
                    push_failure();
                end else begin
                    push_reply(1'b1, SLOT_W'(cur), key_tbl[cur], value_tbl[cur], 1'b1);
                end
            end
            KIND_REMOVE: begin
                if (slot >= SLOTS) begin
                    push_failure();
                end else begin
                    prv = NIL;
                    cur = used_top;
                    while (cur != NIL && cur != LINK_W'(slot)) begin
                        prv = cur;
                        cur = link_tbl[cur];
                    end
                    if (cur == NIL) begin
                        push_failure();
                    end else begin
                        if (prv == NIL) begin
                            used_top = link_tbl[cur];
                        end else begin
                            link_tbl[prv] = link_tbl[cur];
                        end
                        link_tbl[cur] = free_top;
                        free_top      = cur;
                        push_reply(1'b1, SLOT_W'(cur), key_tbl[cur], value_tbl[cur], 1'b1);
                    end
                end
            end
            default: begin
                // A walk emits at most MAX_RESULTS entries and flags the final one.
                if (used_top == NIL) begin
                    push_failure();
                end else begin
                    cur = used_top;
                    n   = 0;
                    while (cur != NIL && n < MAX_RESULTS) begin
                        push_reply(1'b1, SLOT_W'(cur), key_tbl[cur], value_tbl[cur],
                                   (link_tbl[cur] == NIL) || (n + 1 == MAX_RESULTS));
                        cur = link_tbl[cur];
                        n++;
                    end
                end
            end
        endcase
    endtask

    function automatic int live_count();
        logic [LINK_W-1:0] cur;
        int                n;
        cur = used_top;
        n   = 0;
        while (cur != NIL) begin
            cur = link_tbl[cur];
            n++;
        end
        return n;
    endfunction

    function automatic logic [LINK_W-1:0] live_slot(int idx);
        logic [LINK_W-1:0] cur;
        cur = used_top;
        repeat (idx) cur = link_tbl[cur];
        return cur;
    endfunction

    // ------------------------------------------------------------------
    // Traffic
    // ------------------------------------------------------------------

    // Idle stretch length, drawn at random from one of two ranges, the long one rarely.
    function automatic int idle_len();
        if ($urandom_range(0, 99) < 88) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offers one item, holding it until accepted, and feeds the model at the
    // accepting edge. Called and returning just after a rising edge, so valid
    // is raised for a back-to-back item without being lowered in between.
    task automatic send_item(kind_t kind, logic signed [DATA_W-1:0] key,
                             logic [DATA_W-1:0] value, logic [SLOT_W-1:0] slot);
        int gap;
        gap = (calm || $urandom_range(0, 99) < 60) ? 0 : idle_len();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind  <= kind;
        s_key   <= key;
        s_value <= value;
        s_slot  <= slot;
        do @(posedge aclk); while (s_ready !== 1'b1);
        predict_pool_request(kind, key, value, slot);
    endtask

    // Receiver: random stalls of random length, none while calm, and one
    // long hold when a test asks for it.
    initial begin
        forever begin
            @(posedge aclk);
            if (hold_len > 0) begin
                m_ready <= 1'b0;
                repeat (hold_len) @(posedge aclk);
                hold_len = 0;
                m_ready <= 1'b1;
            end else if (!calm && $urandom_range(0, 99) < 25) begin
                m_ready <= 1'b0;
                repeat (idle_len()) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ------------------------------------------------------------------
    // Checking
    // ------------------------------------------------------------------

    task automatic check_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
            mismatches++;
        end
    endtask

    // Every accepted result item is compared with the oldest one predicted.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (pending_replies.size() == 0) begin
                $display("%0t: unexpected item, expected none, got slot %0d ok %b",
                         $time, m_slot_out, m_ok);
                mismatches++;
            end else begin
                head_reply = pending_replies.pop_front();
                check_field("ok",        head_reply.ok,    m_ok);
                check_field("slot_out",  head_reply.slot,  m_slot_out);
                check_field("key_out",   head_reply.key,   m_key_out);
                check_field("value_out", head_reply.value, m_value_out);
                check_field("last",      head_reply.last,  m_last);
            end
        end
    end

    // Watchdog: counts cycles in which neither channel moves an item.
    initial begin
        while (stuck < STUCK_LIMIT) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                stuck = 0;
            end else begin
                stuck++;
            end
        end
        $display("tb_array_linked_list_with_free_list: FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // On an empty pool both a walk and a search must report failure.
    task automatic test_empty_pool();
        send_item(KIND_LIST, $urandom, $urandom, 6'($urandom_range(0, 63)));
        send_item(KIND_SEARCH, 32'h0000_0000, $urandom, 6'($urandom_range(0, 63)));
    endtask

    // Fills all slots with extreme keys and values and a duplicate key, then
    // one more append hits the full pool, and a walk emits the whole list.
    task automatic test_fill_to_full();
        logic [DATA_W-1:0] key;
        logic [DATA_W-1:0] value;
        for (int i = 0; i < SLOTS; i++) begin
            value = $urandom;
            case (i)
                0: begin
                    key   = 32'h8000_0000;
                    value = 32'h0000_0000;
                end
                1: begin
                    key   = 32'h7fff_ffff;
                    value = 32'hffff_ffff;
                end
                2, 9: key = 32'h0000_0000;
                3: begin
                    key   = 32'hffff_ffff;
                    value = 32'h5555_5555;
                end
                default: key = 32'h1000_0000 + i;
            endcase
            send_item(KIND_APPEND, key, value, 6'($urandom_range(0, 63)));
        end
        send_item(KIND_APPEND, 32'h2222_2222, $urandom, 6'd63);
        send_item(KIND_LIST, $urandom, $urandom, 6'($urandom_range(0, 63)));
    endtask

    // A duplicate key returns the earlier entry, the tail entry is found, and
    // a key that was never stored fails.
    task automatic test_search();
        send_item(KIND_SEARCH, 32'h0000_0000, $urandom, 6'($urandom_range(0, 63)));
        send_item(KIND_SEARCH, 32'h1000_0000 + SLOTS - 1, $urandom, 6'd0);
        send_item(KIND_SEARCH, 32'h4000_0000, $urandom, 6'd63);
    endtask

    // Removes the head, the tail and a middle entry, then tries a slot that
    // is already free and two slots outside the pool.
    task automatic test_remove();
        send_item(KIND_REMOVE, $urandom, $urandom, 6'd0);
        send_item(KIND_REMOVE, $urandom, $urandom, 6'(SLOTS - 1));
        send_item(KIND_REMOVE, $urandom, $urandom, 6'd7);
        send_item(KIND_REMOVE, $urandom, $urandom, 6'd0);
        send_item(KIND_REMOVE, $urandom, $urandom, 6'(SLOTS));
        send_item(KIND_REMOVE, $urandom, $urandom, 6'd63);
    endtask

    // The receiver holds off for a long stretch while walks and searches keep
    // being offered, so the block backs up and has to stall its input.
    task automatic test_output_stall();
        calm     = 1'b1;
        hold_len = 250;
        for (int i = 0; i < 12; i++) begin
            send_item((i % 3 == 2) ? KIND_SEARCH : KIND_LIST, $urandom, $urandom,
                      6'($urandom_range(0, 63)));
        end
        calm = 1'b0;
    endtask

    // One random request. The mix leans toward appends when the pool is
    // nearly empty and toward removals when it is nearly full, so the run
    // keeps passing through both the full and the empty pool. Searches and
    // removals mostly target live entries so that they succeed.
    task automatic random_request();
        int                       live;
        int                       pick;
        int                       append_w;
        int                       remove_w;
        kind_t                    kind;
        logic signed [DATA_W-1:0] key;
        logic [SLOT_W-1:0]        slot;
        live     = live_count();
        append_w = (live < 4) ? 55 : (live > 12) ? 15 : 35;
        remove_w = (live < 4) ? 15 : (live > 12) ? 45 : 25;
        pick     = $urandom_range(0, 99);
        if (pick < append_w) begin
            kind = KIND_APPEND;
        end else if (pick < append_w + 25) begin
            kind = KIND_SEARCH;
        end else if (pick < append_w + 25 + remove_w) begin
            kind = KIND_REMOVE;
        end else begin
            kind = KIND_LIST;
        end

        key = ($urandom_range(0, 1) == 0) ? key_pool[$urandom_range(0, 5)] : $urandom;
        if (kind == KIND_SEARCH && live > 0 && $urandom_range(0, 99) < 60) begin
            key = key_tbl[live_slot($urandom_range(0, live - 1))];
        end

        slot = SLOT_W'($urandom_range(0, 63));
        if (kind == KIND_REMOVE) begin
            pick = $urandom_range(0, 99);
            if (pick < 65 && live > 0) begin
                slot = SLOT_W'(live_slot($urandom_range(0, live - 1)));
            end else if (pick < 90) begin
                slot = SLOT_W'($urandom_range(0, SLOTS - 1));
            end
        end
        send_item(kind, key, $urandom, slot);
    endtask

    // Random traffic in phases; the middle phase runs without any idling.
    task automatic test_random_mix();
        for (int phase = 0; phase < 5; phase++) begin
            calm = (phase == 2);
            repeat (30) random_request();
        end
        calm = 1'b0;
    endtask

    initial begin
        reset_pool();
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_empty_pool();
        test_fill_to_full();
        test_search();
        test_remove();
        test_output_stall();
        test_random_mix();
        s_valid <= 1'b0;

        // Let every predicted item arrive, then give the block time to show
        // anything extra it might still produce.
        while (pending_replies.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (mismatches == 0) begin
            $display("tb_array_linked_list_with_free_list: PASS");
        end else begin
            $display("tb_array_linked_list_with_free_list: FAIL");
        end
        $finish;
    end

endmodule
